### hdl/gcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_pkg
// Shared types, constants and GF(2^8) helpers for the circulant column mix.
// ----------------------------------------------------------------------------
package gcm_pkg;

    // Geometry of one state column.
    localparam int ROWS   = 8;
    localparam int BYTE_W = 8;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int IDX_W  = ROW_W + 1;

    // Low byte of the reduction polynomial x^8+x^4+x^3+x^2+1.
    localparam logic [BYTE_W-1:0] GF_POLY_LOW = 8'h1D;

    typedef logic [BYTE_W-1:0] byte_t;

    // One column of bytes, element r is row r.
    typedef byte_t [ROWS-1:0] column_t;

    // Per row, the byte times x^i for i = 0..7.
    typedef byte_t [BYTE_W-1:0] powers_t;
    typedef powers_t [ROWS-1:0] column_powers_t;

    // Per input row k and coefficient offset m, the product coef[m] * row[k].
    typedef column_t [ROWS-1:0] product_grid_t;

    // Coefficient vector after reset: identity transform.
    localparam column_t COEF_RESET = {{(ROWS-1){8'h00}}, 8'h01};

    // Multiply by x modulo the reduction polynomial.
    function automatic byte_t gf_xtime(input byte_t b);
        byte_t shifted;
        shifted = {b[BYTE_W-2:0], 1'b0};
        return b[BYTE_W-1] ? (shifted ^ GF_POLY_LOW) : shifted;
    endfunction

    // Product of a coefficient with a byte given by its precomputed powers.
    function automatic byte_t gf_mul_powers(input byte_t c, input powers_t p);
        byte_t acc;
        acc = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (c[i])
            begin
                acc = acc ^ p[i];
            end
        end
        return acc;
    endfunction

endpackage

### hdl/gcm_power_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_power_stage
// First pipeline stage: forms byte * x^i for every row byte of the column.
// ----------------------------------------------------------------------------
module gcm_power_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    up_valid,
    output logic                    up_ready,
    input  gcm_pkg::column_t        up_column,
    output logic                    dn_valid,
    input  logic                    dn_ready,
    output gcm_pkg::column_powers_t dn_powers
);
    import gcm_pkg::*;

    logic           valid_reg;
    logic           valid_next;
    column_powers_t powers_reg;
    column_powers_t powers_next;

    // The stage takes a transfer when it is empty or its content moves on.
    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    // Chain of xtime steps per row byte.
    always_comb
    begin
        for (int k = 0; k < ROWS; k++)
        begin
            powers_next[k][0] = up_column[k];
            for (int i = 1; i < BYTE_W; i++)
            begin
                powers_next[k][i] = gf_xtime(powers_next[k][i-1]);
            end
        end
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload loads only on an accepted transfer.
    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            powers_reg <= powers_next;
        end
    end

    assign dn_valid  = valid_reg;
    assign dn_powers = powers_reg;

endmodule

### hdl/gcm_product_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_product_stage
// Second pipeline stage: multiplies every row byte by every coefficient.
// ----------------------------------------------------------------------------
module gcm_product_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  gcm_pkg::column_t        coef,
    input  logic                    up_valid,
    output logic                    up_ready,
    input  gcm_pkg::column_powers_t up_powers,
    output logic                    dn_valid,
    input  logic                    dn_ready,
    output gcm_pkg::product_grid_t  dn_products
);
    import gcm_pkg::*;

    logic          valid_reg;
    logic          valid_next;
    product_grid_t products_reg;
    product_grid_t products_next;

    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    // Sixty-four independent GF(2^8) products, each an AND-XOR of the powers.
    always_comb
    begin
        for (int k = 0; k < ROWS; k++)
        begin
            for (int m = 0; m < ROWS; m++)
            begin
                products_next[k][m] = gf_mul_powers(coef[m], up_powers[k]);
            end
        end
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload loads only on an accepted transfer.
    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            products_reg <= products_next;
        end
    end

    assign dn_valid    = valid_reg;
    assign dn_products = products_reg;

endmodule

### hdl/gcm_combine_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_combine_stage
// Last pipeline stage: XORs the circulant selection of products per row.
// ----------------------------------------------------------------------------
module gcm_combine_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   up_valid,
    output logic                   up_ready,
    input  gcm_pkg::product_grid_t up_products,
    output logic                   dn_valid,
    input  logic                   dn_ready,
    output gcm_pkg::column_t       dn_column
);
    import gcm_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    column_t column_reg;
    column_t column_next;

    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    // Row j takes from input row k the product with coefficient (k - j) mod ROWS.
    always_comb
    begin
        logic [ROW_W-1:0] offset;
        offset = '0;
        for (int j = 0; j < ROWS; j++)
        begin
            column_next[j] = '0;
            for (int k = 0; k < ROWS; k++)
            begin
                offset         = ROW_W'(k + ROWS - j);
                column_next[j] = column_next[j] ^ up_products[k][offset];
            end
        end
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload loads only on an accepted transfer.
    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            column_reg <= column_next;
        end
    end

    assign dn_valid  = valid_reg;
    assign dn_column = column_reg;

endmodule

### hdl/gf256_circulant_column_mix_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf256_circulant_column_mix_top
// Circulant GF(2^8) mixing of one 8-byte column with configurable coefficients.
// ----------------------------------------------------------------------------
// The block accepts one 64-bit column per clock while column_in_ready is high
// and delivers the mixed columns in order. Three register stages lie between
// input and output: the xtime powers of each byte, the 64 coefficient products,
// and the XOR of the circulant selection per output row. Each stage holds
// its own valid bit, so a stalled output only backs up the input once all three
// stages are full. Coefficients reset to the identity (coef_0 = 1, the rest 0);
// write them only while no column is in flight. Writes to index 8 and above are
// ignored.
module gf256_circulant_column_mix_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [gcm_pkg::IDX_W-1:0]   cfg_index,
    input  logic [gcm_pkg::BYTE_W-1:0]  cfg_data,
    input  logic                        column_in_valid,
    output logic                        column_in_ready,
    input  logic [63:0]                 column_in,
    output logic                        column_out_valid,
    input  logic                        column_out_ready,
    output logic [63:0]                 column_out
);
    import gcm_pkg::*;

    column_t        coef_reg;
    column_t        coef_next;
    logic           s1_valid;
    logic           s1_ready;
    column_powers_t s1_powers;
    logic           s2_valid;
    logic           s2_ready;
    product_grid_t  s2_products;
    column_t        s3_column;

    // Coefficient register file, written one byte at a time.
    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_we && (cfg_index < IDX_W'(ROWS)))
        begin
            coef_next[cfg_index[ROW_W-1:0]] = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= COEF_RESET;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    // Stage 1: byte powers.
    gcm_power_stage u_power (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (column_in_valid),
        .up_ready  (column_in_ready),
        .up_column (column_t'(column_in)),
        .dn_valid  (s1_valid),
        .dn_ready  (s1_ready),
        .dn_powers (s1_powers)
    );

    // Stage 2: coefficient products.
    gcm_product_stage u_product (
        .clk         (clk),
        .rst_n       (rst_n),
        .coef        (coef_reg),
        .up_valid    (s1_valid),
        .up_ready    (s1_ready),
        .up_powers   (s1_powers),
        .dn_valid    (s2_valid),
        .dn_ready    (s2_ready),
        .dn_products (s2_products)
    );

    // Stage 3: circulant XOR per row.
    gcm_combine_stage u_combine (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (s2_valid),
        .up_ready    (s2_ready),
        .up_products (s2_products),
        .dn_valid    (column_out_valid),
        .dn_ready    (column_out_ready),
        .dn_column   (s3_column)
    );

    assign column_out = 64'(s3_column);

`ifndef SYNTH
    // A write outside the register list leaves every coefficient unchanged.
    a_cfg_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && (cfg_index >= IDX_W'(ROWS)) |=> $stable(coef_reg))
        else $error("coefficient changed by an out-of-range write");

    // A write inside the list lands in the addressed coefficient.
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && (cfg_index < IDX_W'(ROWS))
        |=> coef_reg[$past(cfg_index[ROW_W-1:0])] == $past(cfg_data))
        else $error("coefficient write lost");

    // Input backs up only when every stage is full and the output is stalled.
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !column_in_ready |-> s1_valid && s2_valid && column_out_valid && !column_out_ready)
        else $error("input stalled with room in the pipeline");

    // With all stages full and the output stalled, the input must stall too.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid && s2_valid && column_out_valid && !column_out_ready |-> !column_in_ready)
        else $error("input taken while the pipeline is full");
`endif

endmodule

### tb/gf256_circulant_column_mix_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf256_circulant_column_mix_checker
// Watches the coefficient port and both column channels, predicts each mixed
// column with a local GF(2^8) circulant model and compares it on delivery.
// ----------------------------------------------------------------------------
module gf256_circulant_column_mix_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [gcm_pkg::IDX_W-1:0]   cfg_index,
    input  logic [gcm_pkg::BYTE_W-1:0]  cfg_data,
    input  logic                        column_in_valid,
    input  logic                        column_in_ready,
    input  logic [63:0]                 column_in,
    input  logic                        column_out_valid,
    input  logic                        column_out_ready,
    input  logic [63:0]                 column_out,
    output int                          fail_count,
    output int                          pending_columns
);
    import gcm_pkg::*;

    // Local copy of the coefficient registers and the columns still owed.
    column_t coef_shadow;
    column_t owed_columns[$];
    int      delivered_count;

    // Shift-and-add product in GF(2^8) modulo x^8+x^4+x^3+x^2+1.
    function automatic byte_t gf_times(input byte_t a, input byte_t b);
        byte_t acc;
        byte_t sh;
        acc = '0;
        sh  = b;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (a[i])
            begin
                acc = acc ^ sh;
            end
            sh = sh[BYTE_W-1] ? ({sh[BYTE_W-2:0], 1'b0} ^ GF_POLY_LOW)
                              : {sh[BYTE_W-2:0], 1'b0};
        end
        return acc;
    endfunction

    // Output row j is the XOR over k of coef[(k - j) mod 8] times row k.
    function automatic column_t mixed_column(input column_t col, input column_t coef);
        column_t res;
        for (int j = 0; j < ROWS; j++)
        begin
            res[j] = '0;
            for (int k = 0; k < ROWS; k++)
            begin
                res[j] = res[j] ^ gf_times(coef[(k + ROWS - j) % ROWS], col[k]);
            end
        end
        return res;
    endfunction

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    // Compare on output transfers, predict on input transfers, track writes.
    always @(posedge clk or negedge rst_n)
    begin
        column_t want;
        if (!rst_n)
        begin
            coef_shadow = COEF_RESET;
            owed_columns.delete();
            delivered_count = 0;
        end
        else
        begin
            if (column_out_valid && column_out_ready)
            begin
                if (owed_columns.size() == 0)
                begin
                    report_mismatch($sformatf("column_out %h arrived with none expected",
                                              column_out));
                end
                else
                begin
                    want = owed_columns.pop_front();
                    if (column_out !== want)
                    begin
                        report_mismatch($sformatf("result %0d column_out %h, expected %h",
                                                  delivered_count, column_out, want));
                    end
                end
                delivered_count++;
            end
            if (column_in_valid && column_in_ready)
            begin
                owed_columns = {owed_columns, mixed_column(column_in, coef_shadow)};
            end
            // Writes to indexes beyond the last row are dropped by the block.
            if (cfg_we && cfg_index < ROWS)
            begin
                coef_shadow[cfg_index[ROW_W-1:0]] = cfg_data;
            end
        end
        pending_columns = owed_columns.size();
    end

endmodule

### tb/gf256_circulant_column_mix_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf256_circulant_column_mix_top_tb
// Drives coefficient settings and columns into the circulant column mix with
// random idling on both channels; the checker beside the block does the
// prediction and comparison, and this module gives the verdict.
// ----------------------------------------------------------------------------
module gf256_circulant_column_mix_top_tb;
    import gcm_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 4;
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RAND_PHASES  = 5;
    localparam int PHASE_ITEMS  = 220;
    localparam int IDLE_PERCENT = 26;
    localparam int COEF_FIRST   = 0;
    localparam int UNMAPPED_FIRST = ROWS;
    localparam int UNMAPPED_LAST  = (1 << IDX_W) - 1;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [IDX_W-1:0]   cfg_index;
    logic [BYTE_W-1:0]  cfg_data;
    logic               column_in_valid;
    logic               column_in_ready;
    logic [63:0]        column_in;
    logic               column_out_valid;
    logic               column_out_ready = 1'b0;
    logic [63:0]        column_out;

    int  fail_count;
    int  pending_columns;
    int  cycle_count = 0;
    bit  steady = 1'b0;

    gf256_circulant_column_mix_top DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .column_in_valid  (column_in_valid),
        .column_in_ready  (column_in_ready),
        .column_in        (column_in),
        .column_out_valid (column_out_valid),
        .column_out_ready (column_out_ready),
        .column_out       (column_out)
    );

    gf256_circulant_column_mix_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .column_in_valid  (column_in_valid),
        .column_in_ready  (column_in_ready),
        .column_in        (column_in),
        .column_out_valid (column_out_valid),
        .column_out_ready (column_out_ready),
        .column_out       (column_out),
        .fail_count       (fail_count),
        .pending_columns  (pending_columns)
    );

    // Free-running clock.
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Receiver stalls at random except during a steady stretch.
    always @(negedge clk)
    begin
        column_out_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Cycle limit guards against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // A random column, with some all-zero, all-one and sparse patterns mixed in.
    function automatic column_t random_column();
        column_t col;
        int      pick;
        pick = $urandom_range(9);
        col  = {$urandom(), $urandom()};
        if (pick == 0)
        begin
            col = $urandom_range(1) ? '1 : '0;
        end
        else if (pick == 1)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                if ($urandom_range(1))
                begin
                    col[r] = '0;
                end
            end
        end
        return col;
    endfunction

    // A random coefficient vector, optionally drawn from the edge values only.
    function automatic column_t random_coefs(input bit edges_only);
        column_t coefs;
        byte_t   edge_vals [4] = '{8'h00, 8'h01, 8'h80, 8'hFF};
        for (int m = 0; m < ROWS; m++)
        begin
            coefs[m] = edges_only ? edge_vals[$urandom_range(3)] : byte_t'($urandom_range(255));
        end
        return coefs;
    endfunction

    // One column transfer; called and returns at a falling edge.
    task automatic send_column(input column_t col);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            column_in_valid <= 1'b0;
            @(negedge clk);
        end
        column_in_valid <= 1'b1;
        column_in       <= col;
        @(posedge clk);
        while (!column_in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Stop sending and wait until every owed column has been delivered.
    task automatic drain_columns();
        column_in_valid <= 1'b0;
        @(negedge clk);
        while (pending_columns != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write all eight coefficients, then one write to an unmapped index.
    task automatic load_coefs(input column_t coefs);
        for (int m = 0; m < ROWS; m++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= IDX_W'(COEF_FIRST + m);
            cfg_data  <= coefs[m];
            @(negedge clk);
        end
        cfg_index <= IDX_W'($urandom_range(UNMAPPED_LAST, UNMAPPED_FIRST));
        cfg_data  <= byte_t'($urandom_range(255));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Stimulus and verdict.
    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        column_in_valid = 1'b0;
        column_in       = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset coefficients give the identity transform.
        send_column('0);
        send_column('1);
        send_column(64'h0123_4567_89AB_CDEF);
        send_column(64'h8000_0000_0000_0080);
        drain_columns();

        // All coefficients at the top value.
        load_coefs('1);
        send_column('1);
        send_column(64'h55AA_55AA_55AA_55AA);
        send_column(64'h8000_0000_0000_0000);
        send_column(64'h0000_0000_0000_0001);
        drain_columns();

        // Zero coefficients give a zero column whatever the input.
        load_coefs('0);
        send_column('1);
        send_column(random_column());
        drain_columns();

        // A typical cipher coefficient vector, including zero bytes in the column.
        load_coefs({8'h04, 8'h07, 8'h06, 8'h08, 8'h01, 8'h05, 8'h01, 8'h01});
        send_column('0);
        send_column('1);
        send_column(64'h8080_8080_8080_8080);
        send_column(64'h0001_0000_FF00_0080);
        send_column(64'h0706_0504_0302_0100);
        drain_columns();

        // Random phases, each with its own coefficient setting.
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            load_coefs(random_coefs(p == 1));
            steady = (p == 2);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // Let the pipeline empty completely once in mid-stream.
                if (p == 3 && i == PHASE_ITEMS / 2)
                begin
                    column_in_valid <= 1'b0;
                    @(negedge clk);
                    while (pending_columns != 0)
                    begin
                        @(negedge clk);
                    end
                end
                send_column(random_column());
            end
            drain_columns();
        end
        steady = 1'b0;

        if (fail_count == 0 && pending_columns == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
